// ===== hw/rtl/otsu_pkg.sv =====
// Package for the Otsu threshold finder: widths, scan states, multiplier request and response types.
// No dependencies.
`default_nettype none
package otsu_pkg;
    localparam int COUNT_BITS = 24;
    localparam int BINS       = 256;
    localparam int LVL_BITS   = 8;
    localparam int SUM_BITS   = COUNT_BITS + LVL_BITS;
    localparam int DIFF_BITS  = COUNT_BITS + SUM_BITS + 1;
    localparam int WP_BITS    = 2 * COUNT_BITS;
    localparam int PROD_BITS  = 256;
    localparam int OPA_BITS   = 128;
    localparam int OPB_BITS   = 64;
    localparam int MUL_W      = 32;
    localparam int A_LIMBS    = OPA_BITS / MUL_W;
    localparam int B_LIMBS    = OPB_BITS / MUL_W;
    localparam int LIMB_CNT_BITS = $clog2(A_LIMBS * B_LIMBS + 1);
    localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

    typedef enum logic [3:0] {
        ST_IDLE, ST_CLEAR, ST_READ, ST_ACC, ST_M1, ST_M2, ST_DIFF, ST_M3,
        ST_M4, ST_M5, ST_M6, ST_CMP, ST_DONE
    } state_t;

    typedef struct packed {
        logic                start;
        logic [OPA_BITS-1:0] a;
        logic [OPB_BITS-1:0] b;
    } mul_req_t;

    typedef struct packed {
        logic                 done;
        logic [PROD_BITS-1:0] p;
    } mul_rsp_t;
endpackage
`default_nettype wire

// ===== hw/rtl/otsu_mul.sv =====
// Shared multiplier for the Otsu finder: 128x64 product one 32x32 partial per cycle.
// Depends on otsu_pkg.
`default_nettype none
module otsu_mul (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire otsu_pkg::mul_req_t req,
    output otsu_pkg::mul_rsp_t     rsp
);
    import otsu_pkg::*;

    logic [OPA_BITS-1:0]      a_reg, a_next;
    logic [OPB_BITS-1:0]      b_reg, b_next;
    logic [PROD_BITS-1:0]     acc_reg, acc_next;
    logic [LIMB_CNT_BITS-1:0] cnt_reg, cnt_next;
    logic                     busy_reg, busy_next;
    logic                     done_reg, done_next;
    logic [1:0]               ai;
    logic                     bi;
    logic [2*MUL_W-1:0]       part;
    logic [PROD_BITS-1:0]     part_sh;

    assign ai      = cnt_reg[1:0];
    assign bi      = cnt_reg[2];
    assign part    = a_reg[ai*MUL_W +: MUL_W] * b_reg[bi*MUL_W +: MUL_W];
    assign part_sh = PROD_BITS'(part) << ((32'(ai) + 32'(bi)) * MUL_W);

    always_comb
    begin
        a_next = a_reg; b_next = b_reg; acc_next = acc_reg;
        cnt_next = cnt_reg; busy_next = busy_reg; done_next = 1'b0;
        if (req.start)
        begin
            a_next = req.a; b_next = req.b; acc_next = '0;
            cnt_next = '0; busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next = acc_reg + part_sh;
            cnt_next = cnt_reg + 1'b1;
            if (cnt_reg == LIMB_CNT_BITS'(A_LIMBS * B_LIMBS - 1))
            begin
                busy_next = 1'b0; done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0; done_reg <= 1'b0; cnt_reg <= '0;
        end
        else
        begin
            busy_reg <= busy_next; done_reg <= done_next; cnt_reg <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        a_reg <= a_next; b_reg <= b_next; acc_reg <= acc_next;
    end

    assign rsp.done = done_reg;
    assign rsp.p    = acc_reg;

    a_done_after_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> $past(busy_reg)) else $error("done without busy");
    a_no_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("done while busy");
    a_cnt_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (busy_reg && !req.start && cnt_reg == LIMB_CNT_BITS'(A_LIMBS*B_LIMBS-1)) |=> done_reg)
        else $error("missing done");
endmodule
`default_nettype wire

// ===== hw/rtl/otsu_threshold_finder.sv =====
// Otsu threshold finder top level: histogram memory, scan sequencer, shared multiplier.
// Depends on otsu_pkg and otsu_mul.
// An ordinary pixel keeps busy high through the bin read, then the bin write. A last pixel
// adds the scan: each bin is read and accumulated; each non-empty bin below the top one
// also runs six products on the shared multiplier, then a compare. done then strobes the
// threshold for exactly one cycle, the first of the histogram clearing sweep; the receiver
// cannot stall it. The sequencer accepts a new pixel only in idle, after the prior bin write.
// Reset: control clears at once, then a clearing sweep of all 256 bins runs with busy high.
`default_nettype none
module otsu_threshold_finder (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [otsu_pkg::LVL_BITS-1:0]  pixel,
    input  wire logic                           last_pixel,
    output logic                                done,
    output logic [otsu_pkg::LVL_BITS-1:0]       threshold
);
    import otsu_pkg::*;

    // histogram memory, one write port and one registered read port
    logic [COUNT_BITS-1:0] hist_mem [BINS];
    logic [COUNT_BITS-1:0] rd_reg;
    logic                  we;
    logic [LVL_BITS-1:0]   waddr, raddr;
    logic [COUNT_BITS-1:0] wdata;

    state_t state_reg, state_next;
    logic [LVL_BITS-1:0]   px_reg, px_next;
    logic                  last_reg, last_next;
    logic                  scan_reg, scan_next;  // pixel step vs scan step
    logic [LVL_BITS:0]     t_reg, t_next;         // scan/clear index, 9 bits to hold BINS
    logic [COUNT_BITS-1:0] n_reg, n_next;
    logic [SUM_BITS-1:0]   s_reg, s_next;
    logic [COUNT_BITS-1:0] wb_reg, wb_next;
    logic [SUM_BITS-1:0]   sb_reg, sb_next;
    logic [PROD_BITS-1:0]  x_reg, x_next;        // also holds lhs
    logic [PROD_BITS-1:0]  y_reg, y_next;        // also holds rhs
    logic [DIFF_BITS-1:0]  d_reg, d_next;
    logic [DIFF_BITS-1:0]  bd_reg, bd_next;
    logic [WP_BITS-1:0]    bw_reg, bw_next;
    logic [LVL_BITS-1:0]   bl_reg, bl_next;
    logic                  done_reg, done_next;
    mul_req_t              mreq;
    mul_rsp_t              mrsp;

    logic [COUNT_BITS-1:0] wb_sum, wf;
    logic [WP_BITS-1:0]    wprod;
    logic                  saturated;

    assign saturated = (n_reg == COUNT_MAX);
    assign wb_sum    = wb_reg + rd_reg;
    assign wf        = n_reg - wb_reg;
    assign wprod     = WP_BITS'(wb_reg) * WP_BITS'(wf);

    otsu_mul u_mul (.clk(clk), .rst_n(rst_n), .req(mreq), .rsp(mrsp));

    always_ff @(posedge clk)
    begin
        if (we)
            hist_mem[waddr] <= wdata;
        rd_reg <= hist_mem[raddr];
    end

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:  if (start) state_next = ST_READ;
            ST_CLEAR: if (t_reg == 9'(BINS - 1)) state_next = ST_IDLE;
            ST_READ:  state_next = ST_ACC;
            ST_ACC:
            begin
                if (!scan_reg)
                    state_next = last_reg ? ST_READ : ST_IDLE;
                else if (wb_sum == '0)
                    state_next = (t_reg == 9'(BINS - 1)) ? ST_DONE : ST_READ;
                else if (wb_sum >= n_reg)
                    state_next = ST_DONE;
                else
                    state_next = ST_M1;
            end
            ST_M1:   if (mrsp.done) state_next = ST_M2;
            ST_M2:   if (mrsp.done) state_next = ST_DIFF;
            ST_DIFF: state_next = ST_M3;
            ST_M3:   if (mrsp.done) state_next = ST_M4;
            ST_M4:   if (mrsp.done) state_next = ST_M5;
            ST_M5:   if (mrsp.done) state_next = ST_M6;
            ST_M6:   if (mrsp.done) state_next = ST_CMP;
            ST_CMP:  state_next = (t_reg == 9'(BINS - 1)) ? ST_DONE : ST_READ;
            ST_DONE: state_next = ST_CLEAR;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        px_next = px_reg; last_next = last_reg; scan_next = scan_reg; t_next = t_reg;
        n_next = n_reg; s_next = s_reg; wb_next = wb_reg; sb_next = sb_reg;
        x_next = x_reg; y_next = y_reg; d_next = d_reg;
        bd_next = bd_reg; bw_next = bw_reg; bl_next = bl_reg; done_next = 1'b0;
        we = 1'b0; waddr = t_reg[LVL_BITS-1:0]; wdata = '0;
        raddr = scan_reg ? t_reg[LVL_BITS-1:0] : px_reg;
        mreq.start = 1'b0; mreq.a = '0; mreq.b = '0;
        case (state_reg)
            ST_IDLE:
            if (start)
            begin
                px_next = pixel; last_next = last_pixel; scan_next = 1'b0;
            end
            ST_CLEAR:
            begin
                we = 1'b1;
                t_next = t_reg + 1'b1;
            end
            ST_ACC:
            if (!scan_reg)
            begin
                if (!saturated)
                begin
                    we = 1'b1; waddr = px_reg; wdata = rd_reg + 1'b1;
                    n_next = n_reg + 1'b1;
                    s_next = s_reg + SUM_BITS'(px_reg);
                end
                if (last_reg)
                begin
                    scan_next = 1'b1; t_next = '0; wb_next = '0; sb_next = '0;
                    bd_next = '0; bw_next = WP_BITS'(1); bl_next = '0;
                end
            end
            else
            begin
                wb_next = wb_sum;
                if (wb_sum == '0)
                    t_next = t_reg + 1'b1;
                else if (wb_sum < n_reg)
                begin
                    sb_next = sb_reg + SUM_BITS'(t_reg[LVL_BITS-1:0]) * SUM_BITS'(rd_reg);
                    mreq.start = 1'b1;
                    mreq.a = OPA_BITS'(n_reg);
                    mreq.b = OPB_BITS'(sb_reg + SUM_BITS'(t_reg[LVL_BITS-1:0])
                             * SUM_BITS'(rd_reg));
                end
            end
            ST_M1:
            if (mrsp.done)
            begin
                x_next = mrsp.p;
                mreq.start = 1'b1; mreq.a = OPA_BITS'(s_reg); mreq.b = OPB_BITS'(wb_reg);
            end
            ST_M2:
            if (mrsp.done)
                y_next = mrsp.p;
            ST_DIFF:
            begin
                d_next = (x_reg >= y_reg) ? DIFF_BITS'(x_reg - y_reg) : DIFF_BITS'(y_reg - x_reg);
                mreq.start = 1'b1;
                mreq.a = OPA_BITS'(d_next); mreq.b = OPB_BITS'(d_next);
            end
            ST_M3:
            if (mrsp.done)
            begin
                mreq.start = 1'b1; mreq.a = mrsp.p[OPA_BITS-1:0]; mreq.b = OPB_BITS'(bw_reg);
            end
            ST_M4:
            if (mrsp.done)
            begin
                x_next = mrsp.p;
                mreq.start = 1'b1; mreq.a = OPA_BITS'(bd_reg); mreq.b = OPB_BITS'(bd_reg);
            end
            ST_M5:
            if (mrsp.done)
            begin
                mreq.start = 1'b1; mreq.a = mrsp.p[OPA_BITS-1:0]; mreq.b = OPB_BITS'(wprod);
            end
            ST_M6:
            if (mrsp.done)
                y_next = mrsp.p;
            ST_CMP:
            begin
                if (x_reg > y_reg)
                begin
                    bd_next = d_reg; bw_next = wprod; bl_next = t_reg[LVL_BITS-1:0];
                end
                t_next = t_reg + 1'b1;
            end
            ST_DONE:
            begin
                done_next = 1'b1; t_next = '0; n_next = '0; s_next = '0; scan_next = 1'b0;
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_CLEAR; t_reg <= '0; n_reg <= '0; s_reg <= '0;
            scan_reg <= 1'b0; done_reg <= 1'b0; bl_reg <= '0;
        end
        else
        begin
            state_reg <= state_next; t_reg <= t_next; n_reg <= n_next; s_reg <= s_next;
            scan_reg <= scan_next; done_reg <= done_next; bl_reg <= bl_next;
        end
    end

    always_ff @(posedge clk)
    begin
        px_reg <= px_next; last_reg <= last_next; wb_reg <= wb_next; sb_reg <= sb_next;
        x_reg <= x_next; y_reg <= y_next; d_reg <= d_next; bd_reg <= bd_next;
        bw_reg <= bw_next;
    end

    assign busy      = (state_reg != ST_IDLE);
    assign done      = done_reg;
    assign threshold = bl_reg;

    a_done_one: assert property (@(posedge clk) disable iff (!rst_n)
        done |=> !done) else $error("done longer than one cycle");
    a_done_busy: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> busy) else $error("done while idle");
    a_total_ok: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == ST_ACC && scan_reg) |-> wb_reg < n_reg || wb_reg == '0)
        else $error("background weight overran total");
endmodule
`default_nettype wire
